/* rtl/core/gtts_pkg.sv */
// ----------------------------------------------------------------------------
// Grouped timer task scheduler package
// Sizes, command codes, the slot record and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package gtts_pkg;

    localparam int TASK_SLOTS  = 64;
    localparam int GROUP_COUNT = 16;
    localparam int MAX_FIRES   = 16;
    localparam int TIME_BITS   = 48;

    localparam int IDX_W      = $clog2(TASK_SLOTS);
    localparam int SCAN_W     = IDX_W + 1;
    localparam int FIRE_IDX_W = (MAX_FIRES > 1) ? $clog2(MAX_FIRES) : 1;
    localparam int FIRE_CNT_W = $clog2(MAX_FIRES + 1);

    localparam int CMD_W    = 3;
    localparam int SLOT_W   = 6;
    localparam int GROUP_W  = 4;
    localparam int PERIOD_W = 32;
    localparam int LIMIT_W  = 16;
    localparam int DRIFT_W  = 2;
    localparam int COUNT_W  = 7;
    localparam int TOTAL_W  = 32;

    localparam logic [CMD_W-1:0] CMD_SCHEDULE     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CANCEL_GROUP = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PAUSE_GROUP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESUME_GROUP = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TICK         = 3'd5;

    localparam logic [DRIFT_W-1:0] DRIFT_CATCH_UP  = 2'd1;
    localparam logic [DRIFT_W-1:0] DRIFT_SKIP_LATE = 2'd2;

    typedef struct packed {
        logic                 paused;
        logic [TIME_BITS-1:0] due;
        logic [PERIOD_W-1:0]  period;
        logic                 repeats;
        logic                 limited;
        logic [LIMIT_W-1:0]   limit;
        logic [LIMIT_W-1:0]   runs;
        logic [GROUP_W-1:0]   group;
        logic [DRIFT_W-1:0]   drift;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic capture;
        logic sched;
        logic cancel;
        logic scan_start;
        logic scan_run;
        logic fire_calc;
        logic fire_wr;
        logic end_tick;
        logic set_more;
        logic emit_step;
    } ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             scan_done;
        logic             best_valid;
        logic             fires_full;
        logic             emit_last;
    } sts_t;

    function automatic logic [TIME_BITS-1:0] sat_add(
        input logic [TIME_BITS-1:0] a,
        input logic [TIME_BITS-1:0] b
    );
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction

endpackage

/* rtl/core/gtts_req_if.sv */
// ----------------------------------------------------------------------------
// Scheduler request channel
// Valid/ready channel carrying one command request.
// ----------------------------------------------------------------------------
interface gtts_req_if;
    logic                            valid;
    logic                            ready;
    logic [gtts_pkg::CMD_W-1:0]      cmd;
    logic [gtts_pkg::SLOT_W-1:0]     slot;
    logic [gtts_pkg::GROUP_W-1:0]    group_tag;
    logic [gtts_pkg::TIME_BITS-1:0]  now_ms;
    logic [gtts_pkg::TIME_BITS-1:0]  due_ms;
    logic                            repeats;
    logic [gtts_pkg::PERIOD_W-1:0]   period_ms;
    logic                            run_limited;
    logic [gtts_pkg::LIMIT_W-1:0]    run_limit;
    logic [gtts_pkg::DRIFT_W-1:0]    drift_mode;

    modport source (
        output valid, cmd, slot, group_tag, now_ms, due_ms, repeats, period_ms,
               run_limited, run_limit, drift_mode,
        input  ready
    );
    modport sink (
        input  valid, cmd, slot, group_tag, now_ms, due_ms, repeats, period_ms,
               run_limited, run_limit, drift_mode,
        output ready
    );
endinterface

/* rtl/core/gtts_rsp_if.sv */
// ----------------------------------------------------------------------------
// Scheduler response channel
// Valid/ready channel carrying one result of a request.
// ----------------------------------------------------------------------------
interface gtts_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            fired_valid;
    logic [gtts_pkg::SLOT_W-1:0]     fired_slot;
    logic [gtts_pkg::TIME_BITS-1:0]  fired_due_ms;
    logic [gtts_pkg::LIMIT_W-1:0]    fired_runs_before;
    logic [gtts_pkg::COUNT_W-1:0]    affected_count;
    logic [gtts_pkg::TOTAL_W-1:0]    callbacks_total;
    logic [gtts_pkg::TOTAL_W-1:0]    wakeups_total;
    logic [gtts_pkg::COUNT_W-1:0]    active_total;
    logic                            more_due;
    logic                            last;

    modport source (
        output valid, fired_valid, fired_slot, fired_due_ms, fired_runs_before,
               affected_count, callbacks_total, wakeups_total, active_total,
               more_due, last,
        input  ready
    );
    modport sink (
        input  valid, fired_valid, fired_slot, fired_due_ms, fired_runs_before,
               affected_count, callbacks_total, wakeups_total, active_total,
               more_due, last,
        output ready
    );
endinterface

/* rtl/core/grouped_timer_task_scheduler_top.sv */
// ----------------------------------------------------------------------------
// Grouped timer task scheduler
// Table of 64 timer task slots with group commands and tick firing.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready) and results leave on rsp (valid/ready).
// One request is taken at a time; req.ready is high only while the block is
// idle. Schedule, cancel and unused command codes go from dispatch straight
// to their one result. Group commands scan all 64 slots, one per cycle, and
// then present one result. A tick runs one scan of the slot table for each
// firing plus one final scan, with decide, read, calculate and write steps
// for each fired task, and then presents its first result; the slot table
// RAM read port, one slot per cycle, paces each scan.
// A tick gives one result per fired task (or one empty result when nothing
// fired), at most 16, with last on the final one; all results of a request
// carry the totals after the request completes.
// A stalled rsp.ready holds the current result and the block takes no new
// request until the final result is taken. Reset clears all slots to free
// and both totals to zero; no clearing pass is needed.
module grouped_timer_task_scheduler_top (
    input logic       clk,
    input logic       rst_n,
    gtts_req_if.sink  req,
    gtts_rsp_if.source rsp
);
    gtts_pkg::ctl_t ctl;
    gtts_pkg::sts_t sts;

    gtts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    gtts_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .sts               (sts),
        .cmd               (req.cmd),
        .slot              (req.slot),
        .group_tag         (req.group_tag),
        .now_ms            (req.now_ms),
        .due_ms            (req.due_ms),
        .repeats           (req.repeats),
        .period_ms         (req.period_ms),
        .run_limited       (req.run_limited),
        .run_limit         (req.run_limit),
        .drift_mode        (req.drift_mode),
        .fired_valid       (rsp.fired_valid),
        .fired_slot        (rsp.fired_slot),
        .fired_due_ms      (rsp.fired_due_ms),
        .fired_runs_before (rsp.fired_runs_before),
        .affected_count    (rsp.affected_count),
        .callbacks_total   (rsp.callbacks_total),
        .wakeups_total     (rsp.wakeups_total),
        .active_total      (rsp.active_total),
        .more_due          (rsp.more_due),
        .last              (rsp.last)
    );
endmodule

/* rtl/core/gtts_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gtts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/core/gtts_ctrl.sv */
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences dispatch, slot scans, firing and result delivery.
// ----------------------------------------------------------------------------
module gtts_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  gtts_pkg::sts_t  sts,
    output gtts_pkg::ctl_t  ctl
);
    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_DISPATCH  = 8'b0000_0010,
        ST_SCAN      = 8'b0000_0100,
        ST_DECIDE    = 8'b0000_1000,
        ST_FIRE_RD   = 8'b0001_0000,
        ST_FIRE_CALC = 8'b0010_0000,
        ST_FIRE_WR   = 8'b0100_0000,
        ST_EMIT      = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (sts.cmd)
                    gtts_pkg::CMD_SCHEDULE:
                    begin
                        ctl.sched  = 1'b1;
                        state_next = ST_EMIT;
                    end
                    gtts_pkg::CMD_CANCEL:
                    begin
                        ctl.cancel = 1'b1;
                        state_next = ST_EMIT;
                    end
                    gtts_pkg::CMD_CANCEL_GROUP, gtts_pkg::CMD_PAUSE_GROUP,
                    gtts_pkg::CMD_RESUME_GROUP, gtts_pkg::CMD_TICK:
                    begin
                        ctl.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_SCAN:
            begin
                ctl.scan_run = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = (sts.cmd == gtts_pkg::CMD_TICK) ? ST_DECIDE : ST_EMIT;
                end
            end
            ST_DECIDE:
            begin
                if (!sts.best_valid)
                begin
                    ctl.end_tick = 1'b1;
                    state_next   = ST_EMIT;
                end
                else if (sts.fires_full)
                begin
                    // The cap was reached and one more task is still due.
                    ctl.set_more = 1'b1;
                    ctl.end_tick = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    state_next = ST_FIRE_RD;
                end
            end
            ST_FIRE_RD:
            begin
                state_next = ST_FIRE_CALC;
            end
            ST_FIRE_CALC:
            begin
                ctl.fire_calc = 1'b1;
                state_next    = ST_FIRE_WR;
            end
            ST_FIRE_WR:
            begin
                ctl.fire_wr    = 1'b1;
                ctl.scan_start = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (sts.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ctl.emit_step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

/* rtl/core/gtts_datapath.sv */
// ----------------------------------------------------------------------------
// Scheduler datapath
// Slot table, scan pipeline, due time arithmetic, fire buffer and counters.
// ----------------------------------------------------------------------------
module gtts_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gtts_pkg::ctl_t                   ctl,
    output gtts_pkg::sts_t                   sts,
    input  logic [gtts_pkg::CMD_W-1:0]       cmd,
    input  logic [gtts_pkg::SLOT_W-1:0]      slot,
    input  logic [gtts_pkg::GROUP_W-1:0]     group_tag,
    input  logic [gtts_pkg::TIME_BITS-1:0]   now_ms,
    input  logic [gtts_pkg::TIME_BITS-1:0]   due_ms,
    input  logic                             repeats,
    input  logic [gtts_pkg::PERIOD_W-1:0]    period_ms,
    input  logic                             run_limited,
    input  logic [gtts_pkg::LIMIT_W-1:0]     run_limit,
    input  logic [gtts_pkg::DRIFT_W-1:0]     drift_mode,
    output logic                             fired_valid,
    output logic [gtts_pkg::SLOT_W-1:0]      fired_slot,
    output logic [gtts_pkg::TIME_BITS-1:0]   fired_due_ms,
    output logic [gtts_pkg::LIMIT_W-1:0]     fired_runs_before,
    output logic [gtts_pkg::COUNT_W-1:0]     affected_count,
    output logic [gtts_pkg::TOTAL_W-1:0]     callbacks_total,
    output logic [gtts_pkg::TOTAL_W-1:0]     wakeups_total,
    output logic [gtts_pkg::COUNT_W-1:0]     active_total,
    output logic                             more_due,
    output logic                             last
);
    // Captured request.
    logic [gtts_pkg::CMD_W-1:0]     cmd_reg;
    logic [gtts_pkg::SLOT_W-1:0]    slot_reg;
    logic [gtts_pkg::GROUP_W-1:0]   grp_reg;
    logic [gtts_pkg::TIME_BITS-1:0] now_reg;
    logic [gtts_pkg::TIME_BITS-1:0] now1_reg;
    logic [gtts_pkg::TIME_BITS-1:0] due_in_reg;
    logic                           rep_reg;
    logic [gtts_pkg::PERIOD_W-1:0]  per_reg;
    logic                           lim_en_reg;
    logic [gtts_pkg::LIMIT_W-1:0]   lim_reg;
    logic [gtts_pkg::DRIFT_W-1:0]   drift_reg;

    logic [gtts_pkg::TASK_SLOTS-1:0] active_reg;
    logic [gtts_pkg::COUNT_W-1:0]    act_reg;
    logic [gtts_pkg::COUNT_W-1:0]    aff_reg;
    logic [gtts_pkg::TOTAL_W-1:0]    cb_reg;
    logic [gtts_pkg::TOTAL_W-1:0]    wk_reg;
    logic [gtts_pkg::FIRE_CNT_W-1:0] n_reg;
    logic [gtts_pkg::FIRE_IDX_W-1:0] k_reg;
    logic                            more_reg;

    logic [gtts_pkg::SCAN_W-1:0]    rd_idx_reg;
    logic                           proc_valid_reg;
    logic [gtts_pkg::IDX_W-1:0]     proc_idx_reg;
    logic                           best_valid_reg;
    logic [gtts_pkg::IDX_W-1:0]     best_slot_reg;
    logic [gtts_pkg::TIME_BITS-1:0] best_due_reg;

    gtts_pkg::rec_t                 rec_reg;
    logic [gtts_pkg::TIME_BITS-1:0] sum_a_reg;
    logic [gtts_pkg::TIME_BITS-1:0] sum_c_reg;

    logic [gtts_pkg::SLOT_W-1:0]    buf_slot [gtts_pkg::MAX_FIRES];
    logic [gtts_pkg::TIME_BITS-1:0] buf_due  [gtts_pkg::MAX_FIRES];
    logic [gtts_pkg::LIMIT_W-1:0]   buf_runs [gtts_pkg::MAX_FIRES];

    // RAM port.
    logic                       ram_we;
    logic [gtts_pkg::IDX_W-1:0] ram_waddr;
    gtts_pkg::rec_t             ram_wdata;
    logic [gtts_pkg::IDX_W-1:0] ram_raddr;
    gtts_pkg::rec_t             ram_rdata;

    gtts_ram #(
        .WIDTH (gtts_pkg::REC_W),
        .DEPTH (gtts_pkg::TASK_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic                           slot_ok;
    logic                           grp_ok;
    logic [gtts_pkg::IDX_W-1:0]     slot_idx;
    logic                           proc_on;
    logic                           grp_hit;
    logic                           eligible;
    logic [gtts_pkg::LIMIT_W-1:0]   runs_new;
    logic                           keep;
    logic [gtts_pkg::TIME_BITS-1:0] new_due;
    logic [gtts_pkg::TIME_BITS-1:0] iv;
    logic                           set_act;
    logic                           clr_act;
    logic [gtts_pkg::IDX_W-1:0]     act_idx;
    logic                           aff_inc;
    logic                           emit_last;

    assign slot_ok  = (32'(slot_reg) < gtts_pkg::TASK_SLOTS);
    assign grp_ok   = (32'(grp_reg) < gtts_pkg::GROUP_COUNT);
    assign slot_idx = slot_reg[gtts_pkg::IDX_W-1:0];
    assign proc_on  = ctl.scan_run && proc_valid_reg;
    assign grp_hit  = active_reg[proc_idx_reg] && (ram_rdata.group == grp_reg) && grp_ok;
    assign eligible = active_reg[proc_idx_reg] && !ram_rdata.paused
                      && (ram_rdata.due <= now_reg);
    assign ram_raddr = ctl.scan_run ? rd_idx_reg[gtts_pkg::IDX_W-1:0] : best_slot_reg;

    assign iv = (ram_rdata.period == '0) ? gtts_pkg::TIME_BITS'(1)
                                        : gtts_pkg::TIME_BITS'(ram_rdata.period);

    assign runs_new = (rec_reg.runs == {gtts_pkg::LIMIT_W{1'b1}}) ? rec_reg.runs
                                                                 : rec_reg.runs + 1'b1;
    assign keep = rec_reg.repeats && (!rec_reg.limited || (runs_new < rec_reg.limit));

    always_comb
    begin
        case (rec_reg.drift)
            gtts_pkg::DRIFT_CATCH_UP:  new_due = sum_a_reg;
            gtts_pkg::DRIFT_SKIP_LATE: new_due = sum_c_reg;
            default:                   new_due = (sum_a_reg > now1_reg) ? sum_a_reg : now1_reg;
        endcase
    end

    // Slot table writes and active bit changes; at most one of each per cycle.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = proc_idx_reg;
        ram_wdata = ram_rdata;
        set_act   = 1'b0;
        clr_act   = 1'b0;
        act_idx   = proc_idx_reg;
        aff_inc   = 1'b0;
        if (ctl.sched && slot_ok && grp_ok)
        begin
            ram_we            = 1'b1;
            ram_waddr         = slot_idx;
            ram_wdata.paused  = 1'b0;
            ram_wdata.due     = due_in_reg;
            ram_wdata.period  = per_reg;
            ram_wdata.repeats = rep_reg;
            ram_wdata.limited = lim_en_reg;
            ram_wdata.limit   = lim_reg;
            ram_wdata.runs    = '0;
            ram_wdata.group   = grp_reg;
            ram_wdata.drift   = drift_reg;
            set_act           = 1'b1;
            act_idx           = slot_idx;
        end
        else if (ctl.cancel && slot_ok)
        begin
            clr_act = 1'b1;
            act_idx = slot_idx;
        end
        else if (ctl.fire_wr)
        begin
            act_idx = best_slot_reg;
            if (keep)
            begin
                ram_we         = 1'b1;
                ram_waddr      = best_slot_reg;
                ram_wdata      = rec_reg;
                ram_wdata.due  = new_due;
                ram_wdata.runs = runs_new;
            end
            else
            begin
                clr_act = 1'b1;
            end
        end
        else if (proc_on && grp_hit)
        begin
            case (cmd_reg)
                gtts_pkg::CMD_CANCEL_GROUP:
                begin
                    clr_act = 1'b1;
                    aff_inc = 1'b1;
                end
                gtts_pkg::CMD_PAUSE_GROUP:
                begin
                    if (!ram_rdata.paused)
                    begin
                        ram_we           = 1'b1;
                        ram_wdata.paused = 1'b1;
                        aff_inc          = 1'b1;
                    end
                end
                gtts_pkg::CMD_RESUME_GROUP:
                begin
                    if (ram_rdata.paused)
                    begin
                        ram_we           = 1'b1;
                        ram_wdata.paused = 1'b0;
                        if (ram_rdata.due < now1_reg)
                        begin
                            ram_wdata.due = now1_reg;
                        end
                        aff_inc = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            act_reg        <= '0;
            aff_reg        <= '0;
            cb_reg         <= '0;
            wk_reg         <= '0;
            n_reg          <= '0;
            k_reg          <= '0;
            more_reg       <= 1'b0;
            rd_idx_reg     <= '0;
            proc_valid_reg <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            if (set_act)
            begin
                active_reg[act_idx] <= 1'b1;
                if (!active_reg[act_idx])
                begin
                    act_reg <= act_reg + 1'b1;
                end
            end
            else if (clr_act && active_reg[act_idx])
            begin
                active_reg[act_idx] <= 1'b0;
                act_reg             <= act_reg - 1'b1;
            end

            if (ctl.capture)
            begin
                aff_reg  <= '0;
                n_reg    <= '0;
                k_reg    <= '0;
                more_reg <= 1'b0;
            end
            else
            begin
                if (aff_inc)
                begin
                    aff_reg <= aff_reg + 1'b1;
                end
                if (ctl.fire_wr)
                begin
                    n_reg  <= n_reg + 1'b1;
                    cb_reg <= cb_reg + 1'b1;
                end
                if (ctl.end_tick && (n_reg != '0))
                begin
                    wk_reg <= wk_reg + 1'b1;
                end
                if (ctl.set_more)
                begin
                    more_reg <= 1'b1;
                end
                if (ctl.emit_step)
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end

            if (ctl.scan_start)
            begin
                rd_idx_reg     <= '0;
                proc_valid_reg <= 1'b0;
                best_valid_reg <= 1'b0;
            end
            else if (ctl.scan_run)
            begin
                if (rd_idx_reg < gtts_pkg::SCAN_W'(gtts_pkg::TASK_SLOTS))
                begin
                    rd_idx_reg     <= rd_idx_reg + 1'b1;
                    proc_valid_reg <= 1'b1;
                end
                else
                begin
                    proc_valid_reg <= 1'b0;
                end
                // Strictly earlier wins, so ties stay with the lower slot.
                if (proc_on && eligible
                    && (!best_valid_reg || (ram_rdata.due < best_due_reg)))
                begin
                    best_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg    <= cmd;
            slot_reg   <= slot;
            grp_reg    <= group_tag;
            now_reg    <= now_ms;
            now1_reg   <= gtts_pkg::sat_add(now_ms, gtts_pkg::TIME_BITS'(1));
            due_in_reg <= due_ms;
            rep_reg    <= repeats;
            per_reg    <= period_ms;
            lim_en_reg <= run_limited;
            lim_reg    <= run_limit;
            drift_reg  <= drift_mode;
        end
        if (ctl.scan_run)
        begin
            proc_idx_reg <= rd_idx_reg[gtts_pkg::IDX_W-1:0];
            if (proc_on && eligible
                && (!best_valid_reg || (ram_rdata.due < best_due_reg)))
            begin
                best_slot_reg <= proc_idx_reg;
                best_due_reg  <= ram_rdata.due;
            end
        end
        if (ctl.fire_calc)
        begin
            rec_reg   <= ram_rdata;
            sum_a_reg <= gtts_pkg::sat_add(ram_rdata.due, iv);
            sum_c_reg <= gtts_pkg::sat_add(now_reg, iv);
        end
        if (ctl.fire_wr)
        begin
            buf_slot[n_reg[gtts_pkg::FIRE_IDX_W-1:0]] <= gtts_pkg::SLOT_W'(best_slot_reg);
            buf_due[n_reg[gtts_pkg::FIRE_IDX_W-1:0]]  <= rec_reg.due;
            buf_runs[n_reg[gtts_pkg::FIRE_IDX_W-1:0]] <= rec_reg.runs;
        end
    end

    assign emit_last = (n_reg == '0)
                       || (gtts_pkg::FIRE_CNT_W'(k_reg) == (n_reg - 1'b1));

    assign sts.cmd        = cmd_reg;
    assign sts.scan_done  = proc_on && (rd_idx_reg == gtts_pkg::SCAN_W'(gtts_pkg::TASK_SLOTS))
                            && (proc_idx_reg == gtts_pkg::IDX_W'(gtts_pkg::TASK_SLOTS - 1));
    assign sts.best_valid = best_valid_reg;
    assign sts.fires_full = (n_reg == gtts_pkg::FIRE_CNT_W'(gtts_pkg::MAX_FIRES));
    assign sts.emit_last  = emit_last;

    assign fired_valid       = (n_reg != '0);
    assign fired_slot        = fired_valid ? buf_slot[k_reg] : '0;
    assign fired_due_ms      = fired_valid ? buf_due[k_reg] : '0;
    assign fired_runs_before = fired_valid ? buf_runs[k_reg] : '0;
    assign affected_count    = aff_reg;
    assign callbacks_total   = cb_reg;
    assign wakeups_total     = wk_reg;
    assign active_total      = act_reg;
    assign more_due          = more_reg && emit_last;
    assign last              = emit_last;

    // The running active count tracks the active bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(act_reg) == $countones(active_reg))
        else $error("active count out of step with active bits");

    assert property (@(posedge clk) disable iff (!rst_n)
        32'(n_reg) <= gtts_pkg::MAX_FIRES)
        else $error("fire count beyond cap");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fire_wr |-> best_valid_reg && !sts.fires_full)
        else $error("fire without a due slot or past the cap");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.set_more |-> sts.fires_full && best_valid_reg)
        else $error("more_due set without a full tick");
endmodule

/* tb/tb_pkg.sv */
// ----------------------------------------------------------------------------
// Scheduler testbench types
// Request and result records shared by the stimulus, predictor and checker.
// ----------------------------------------------------------------------------
package tb_pkg;

    localparam logic [gtts_pkg::CMD_W-1:0]     CMD_READ_STATS = 3'd6;
    localparam logic [gtts_pkg::CMD_W-1:0]     CMD_SPARE      = 3'd7;
    localparam logic [gtts_pkg::TIME_BITS-1:0] TIME_MAX       = {gtts_pkg::TIME_BITS{1'b1}};

    typedef struct packed {
        logic [gtts_pkg::CMD_W-1:0]     cmd;
        logic [gtts_pkg::SLOT_W-1:0]    slot;
        logic [gtts_pkg::GROUP_W-1:0]   group_tag;
        logic [gtts_pkg::TIME_BITS-1:0] now_ms;
        logic [gtts_pkg::TIME_BITS-1:0] due_ms;
        logic                           repeats;
        logic [gtts_pkg::PERIOD_W-1:0]  period_ms;
        logic                           run_limited;
        logic [gtts_pkg::LIMIT_W-1:0]   run_limit;
        logic [gtts_pkg::DRIFT_W-1:0]   drift_mode;
    } sched_req_t;

    typedef struct packed {
        logic                           fired_valid;
        logic [gtts_pkg::SLOT_W-1:0]    fired_slot;
        logic [gtts_pkg::TIME_BITS-1:0] fired_due_ms;
        logic [gtts_pkg::LIMIT_W-1:0]   fired_runs_before;
        logic [gtts_pkg::COUNT_W-1:0]   affected_count;
        logic [gtts_pkg::TOTAL_W-1:0]   callbacks_total;
        logic [gtts_pkg::TOTAL_W-1:0]   wakeups_total;
        logic [gtts_pkg::COUNT_W-1:0]   active_total;
        logic                           more_due;
        logic                           last;
    } sched_rsp_t;

endpackage

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Grouped timer task scheduler testbench
// Drives directed and random command requests with random idle bursts on
// both channels, predicts every result from a local slot table and checks
// each field of each result in order.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 20000;

    logic clk;
    logic rst_n;

    gtts_req_if req ();
    gtts_rsp_if rsp ();

    grouped_timer_task_scheduler_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Predictor copy of the slot table.
    gtts_pkg::rec_t tbl [gtts_pkg::TASK_SLOTS];
    logic           live [gtts_pkg::TASK_SLOTS];
    logic [31:0]    fired_count;
    logic [31:0]    tick_count;

    tb_pkg::sched_req_t pending_reqs[$];
    tb_pkg::sched_rsp_t expected_rsps[$];

    int  error_count;
    int  accepted_reqs;
    int  checked_rsps;
    int  fires_seen;
    int  idle_cycles;
    bit  quiet_phase;
    bit  stim_done;
    bit  req_sent;
    int  req_gap;
    int  rsp_gap;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [gtts_pkg::TIME_BITS-1:0] add_clamped(
        input logic [gtts_pkg::TIME_BITS-1:0] a,
        input logic [gtts_pkg::TIME_BITS-1:0] b
    );
        logic [gtts_pkg::TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[gtts_pkg::TIME_BITS] ? tb_pkg::TIME_MAX : s[gtts_pkg::TIME_BITS-1:0];
    endfunction

    function automatic int earliest_due(input logic [gtts_pkg::TIME_BITS-1:0] now);
        int best;
        best = -1;
        for (int i = 0; i < gtts_pkg::TASK_SLOTS; i++)
        begin
            if (live[i] && !tbl[i].paused && tbl[i].due <= now)
            begin
                if (best < 0 || tbl[i].due < tbl[best].due)
                    best = i;
            end
        end
        return best;
    endfunction

    task automatic predict_results(input tb_pkg::sched_req_t r);
        tb_pkg::sched_rsp_t outs[$];
        tb_pkg::sched_rsp_t o;
        logic [gtts_pkg::COUNT_W-1:0] hits;
        logic [gtts_pkg::COUNT_W-1:0] act;
        logic [gtts_pkg::TIME_BITS-1:0] iv;
        logic [gtts_pkg::TIME_BITS-1:0] a;
        logic [gtts_pkg::TIME_BITS-1:0] b;
        bit more;
        int s;
        hits = '0;
        more = 1'b0;
        case (r.cmd)
            gtts_pkg::CMD_SCHEDULE:
            begin
                live[r.slot] = 1'b1;
                tbl[r.slot].paused = 1'b0;
                tbl[r.slot].runs = '0;
                tbl[r.slot].due = r.due_ms;
                tbl[r.slot].repeats = r.repeats;
                tbl[r.slot].period = r.period_ms;
                tbl[r.slot].limited = r.run_limited;
                tbl[r.slot].limit = r.run_limit;
                tbl[r.slot].group = r.group_tag;
                tbl[r.slot].drift = r.drift_mode;
            end
            gtts_pkg::CMD_CANCEL:
                live[r.slot] = 1'b0;
            gtts_pkg::CMD_CANCEL_GROUP, gtts_pkg::CMD_PAUSE_GROUP,
            gtts_pkg::CMD_RESUME_GROUP:
            begin
                for (int i = 0; i < gtts_pkg::TASK_SLOTS; i++)
                begin
                    if (!live[i] || tbl[i].group != r.group_tag)
                        continue;
                    if (r.cmd == gtts_pkg::CMD_CANCEL_GROUP)
                    begin
                        live[i] = 1'b0;
                        hits++;
                    end
                    else if (r.cmd == gtts_pkg::CMD_PAUSE_GROUP)
                    begin
                        if (!tbl[i].paused)
                        begin
                            tbl[i].paused = 1'b1;
                            hits++;
                        end
                    end
                    else if (tbl[i].paused)
                    begin
                        b = add_clamped(r.now_ms, gtts_pkg::TIME_BITS'(1));
                        tbl[i].paused = 1'b0;
                        if (tbl[i].due < b)
                            tbl[i].due = b;
                        hits++;
                    end
                end
            end
            gtts_pkg::CMD_TICK:
            begin
                while (outs.size() < gtts_pkg::MAX_FIRES)
                begin
                    s = earliest_due(r.now_ms);
                    if (s < 0)
                        break;
                    o = '0;
                    o.fired_valid = 1'b1;
                    o.fired_slot = s[gtts_pkg::SLOT_W-1:0];
                    o.fired_due_ms = tbl[s].due;
                    o.fired_runs_before = tbl[s].runs;
                    outs.insert(outs.size(), o);
                    fired_count++;
                    if (tbl[s].runs != '1)
                        tbl[s].runs++;
                    if (tbl[s].repeats && (!tbl[s].limited || tbl[s].runs < tbl[s].limit))
                    begin
                        iv = (tbl[s].period == '0) ? gtts_pkg::TIME_BITS'(1)
                                                   : gtts_pkg::TIME_BITS'(tbl[s].period);
                        if (tbl[s].drift == gtts_pkg::DRIFT_CATCH_UP)
                            tbl[s].due = add_clamped(tbl[s].due, iv);
                        else if (tbl[s].drift == gtts_pkg::DRIFT_SKIP_LATE)
                            tbl[s].due = add_clamped(r.now_ms, iv);
                        else
                        begin
                            a = add_clamped(tbl[s].due, iv);
                            b = add_clamped(r.now_ms, gtts_pkg::TIME_BITS'(1));
                            tbl[s].due = (a > b) ? a : b;
                        end
                    end
                    else
                        live[s] = 1'b0;
                end
                if (outs.size() > 0)
                    tick_count++;
                if (outs.size() == gtts_pkg::MAX_FIRES)
                    more = earliest_due(r.now_ms) >= 0;
            end
            default: ;
        endcase
        if (outs.size() == 0)
        begin
            o = '0;
            outs.insert(0, o);
        end
        act = '0;
        for (int i = 0; i < gtts_pkg::TASK_SLOTS; i++)
            act = act + gtts_pkg::COUNT_W'(live[i]);
        for (int k = 0; k < outs.size(); k++)
        begin
            o = outs[k];
            o.affected_count = hits;
            o.callbacks_total = fired_count;
            o.wakeups_total = tick_count;
            o.active_total = act;
            o.more_due = (k == outs.size() - 1) && more;
            o.last = (k == outs.size() - 1);
            expected_rsps.insert(expected_rsps.size(), o);
        end
    endtask

    function automatic tb_pkg::sched_req_t random_fields();
        tb_pkg::sched_req_t r;
        r.cmd = gtts_pkg::CMD_SCHEDULE;
        r.slot = gtts_pkg::SLOT_W'($urandom_range(0, gtts_pkg::TASK_SLOTS - 1));
        r.group_tag = gtts_pkg::GROUP_W'($urandom_range(0, 3));
        r.now_ms = gtts_pkg::TIME_BITS'({$urandom, $urandom});
        r.due_ms = gtts_pkg::TIME_BITS'($urandom_range(0, 400));
        r.repeats = 1'($urandom);
        r.period_ms = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 60);
        r.run_limited = 1'($urandom);
        r.run_limit = gtts_pkg::LIMIT_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                                      : $urandom_range(0, 5));
        r.drift_mode = gtts_pkg::DRIFT_W'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
            r.due_ms = gtts_pkg::TIME_BITS'({$urandom, $urandom});
        return r;
    endfunction

    task automatic add_req(input tb_pkg::sched_req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // Stimulus: a directed opening, then random traffic with rising tick times.
    initial
    begin
        tb_pkg::sched_req_t r;
        logic [gtts_pkg::TIME_BITS-1:0] clock_ms;
        int pick;
        stim_done = 1'b0;
        quiet_phase = 1'b0;

        // Sixteen tasks due at once exercise the per-tick cap and more_due.
        for (int i = 0; i < 17; i++)
        begin
            r = random_fields();
            r.slot = (i == 16) ? gtts_pkg::SLOT_W'(gtts_pkg::TASK_SLOTS - 1)
                               : gtts_pkg::SLOT_W'(i);
            r.group_tag = (i == 16) ? gtts_pkg::GROUP_W'(gtts_pkg::GROUP_COUNT - 1)
                                    : gtts_pkg::GROUP_W'(i % 2);
            r.due_ms = (i == 16) ? tb_pkg::TIME_MAX : gtts_pkg::TIME_BITS'(10);
            r.repeats = (i % 3 != 0);
            r.period_ms = (i == 5) ? '1 : gtts_pkg::PERIOD_W'(i % 4);
            r.run_limited = 1'(i % 2);
            r.run_limit = (i == 7) ? '1 : gtts_pkg::LIMIT_W'(i % 3);
            r.drift_mode = gtts_pkg::DRIFT_W'(i % 4);
            add_req(r);
        end
        r = random_fields();
        r.cmd = gtts_pkg::CMD_TICK; r.now_ms = gtts_pkg::TIME_BITS'(20); add_req(r);
        r.cmd = gtts_pkg::CMD_PAUSE_GROUP; r.group_tag = gtts_pkg::GROUP_W'(1); add_req(r);
        r.cmd = gtts_pkg::CMD_PAUSE_GROUP; add_req(r);
        r.cmd = gtts_pkg::CMD_RESUME_GROUP; r.now_ms = gtts_pkg::TIME_BITS'(500); add_req(r);
        r.cmd = gtts_pkg::CMD_CANCEL_GROUP; r.group_tag = gtts_pkg::GROUP_W'(0); add_req(r);
        r.cmd = gtts_pkg::CMD_CANCEL; r.slot = gtts_pkg::SLOT_W'(0); add_req(r);
        r.cmd = tb_pkg::CMD_READ_STATS; add_req(r);
        r.cmd = tb_pkg::CMD_SPARE; add_req(r);
        // Late time: the max-due task fires and saturated requeues occur.
        r.cmd = gtts_pkg::CMD_TICK; r.now_ms = tb_pkg::TIME_MAX; add_req(r);

        clock_ms = '0;
        for (int n = 0; n < 92; n++)
        begin
            r = random_fields();
            pick = $urandom_range(0, 99);
            if (pick < 40)
                r.due_ms = clock_ms + gtts_pkg::TIME_BITS'($urandom_range(0, 200));
            else if (pick < 65)
            begin
                r.cmd = gtts_pkg::CMD_TICK;
                clock_ms = clock_ms + gtts_pkg::TIME_BITS'($urandom_range(0, 120));
                r.now_ms = clock_ms;
            end
            else if (pick < 73)
                r.cmd = gtts_pkg::CMD_CANCEL;
            else if (pick < 79)
                r.cmd = gtts_pkg::CMD_CANCEL_GROUP;
            else if (pick < 87)
                r.cmd = gtts_pkg::CMD_PAUSE_GROUP;
            else if (pick < 95)
            begin
                r.cmd = gtts_pkg::CMD_RESUME_GROUP;
                r.now_ms = clock_ms;
            end
            else
                r.cmd = ($urandom_range(0, 1) == 0) ? tb_pkg::CMD_READ_STATS : tb_pkg::CMD_SPARE;
            add_req(r);
        end
        // Random fields above cover all bits of the wide inputs; a full random
        // now on a tick drains most due tasks at the end.
        r = random_fields();
        r.cmd = gtts_pkg::CMD_TICK; r.now_ms = gtts_pkg::TIME_BITS'({$urandom, $urandom});
        add_req(r);
        r.cmd = gtts_pkg::CMD_TICK; r.now_ms = tb_pkg::TIME_MAX; add_req(r);

        wait (pending_reqs.size() < 30);
        quiet_phase = 1'b1;
        wait (pending_reqs.size() == 0 && !req.valid);
        stim_done = 1'b1;
    end

    // Driver: one request at a time, changed at the falling edge.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.cmd <= tb_pkg::CMD_READ_STATS;
            req.slot <= '0;
            req.group_tag <= '0;
            req.now_ms <= '0;
            req.due_ms <= '0;
            req.repeats <= 1'b0;
            req.period_ms <= '0;
            req.run_limited <= 1'b0;
            req.run_limit <= '0;
            req.drift_mode <= '0;
            req_gap = 0;
            req_sent = 1'b0;
        end
        else if (!req.valid || req_sent)
        begin
            // req_sent marks the accepted request from the rising edge.
            req_sent = 1'b0;
            if (req_gap > 0)
            begin
                req_gap--;
                req.valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0 && !quiet_phase && $urandom_range(0, 5) == 0)
            begin
                req_gap = $urandom_range(1, 10);
                req.valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                tb_pkg::sched_req_t r;
                r = pending_reqs.pop_front();
                req.valid <= 1'b1;
                req.cmd <= r.cmd;
                req.slot <= r.slot;
                req.group_tag <= r.group_tag;
                req.now_ms <= r.now_ms;
                req.due_ms <= r.due_ms;
                req.repeats <= r.repeats;
                req.period_ms <= r.period_ms;
                req.run_limited <= r.run_limited;
                req.run_limit <= r.run_limit;
                req.drift_mode <= r.drift_mode;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // Result side stalls in bursts as well.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rsp_gap = 0;
        end
        else if (rsp_gap > 0)
        begin
            rsp_gap--;
            rsp.ready <= 1'b0;
        end
        else if (!quiet_phase && $urandom_range(0, 7) == 0)
        begin
            rsp_gap = $urandom_range(1, 10);
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= 1'b1;
    end

    // Monitor: requests feed the predictor, results are checked in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                tb_pkg::sched_req_t r;
                r.cmd = req.cmd;
                r.slot = req.slot;
                r.group_tag = req.group_tag;
                r.now_ms = req.now_ms;
                r.due_ms = req.due_ms;
                r.repeats = req.repeats;
                r.period_ms = req.period_ms;
                r.run_limited = req.run_limited;
                r.run_limit = req.run_limit;
                r.drift_mode = req.drift_mode;
                predict_results(r);
                accepted_reqs++;
                req_sent = 1'b1;
            end
            if (rsp.valid && rsp.ready)
            begin
                tb_pkg::sched_rsp_t e;
                checked_rsps++;
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected result: no request outstanding");
                    error_count++;
                end
                else
                begin
                    e = expected_rsps.pop_front();
                    fires_seen += e.fired_valid;
                    if (rsp.fired_valid !== e.fired_valid)
                    begin
                        $error("fired_valid: expected %0d, got %0d", e.fired_valid,
                               rsp.fired_valid);
                        error_count++;
                    end
                    if (rsp.fired_slot !== e.fired_slot)
                    begin
                        $error("fired_slot: expected %0d, got %0d", e.fired_slot,
                               rsp.fired_slot);
                        error_count++;
                    end
                    if (rsp.fired_due_ms !== e.fired_due_ms)
                    begin
                        $error("fired_due_ms: expected %0d, got %0d", e.fired_due_ms,
                               rsp.fired_due_ms);
                        error_count++;
                    end
                    if (rsp.fired_runs_before !== e.fired_runs_before)
                    begin
                        $error("fired_runs_before: expected %0d, got %0d",
                               e.fired_runs_before, rsp.fired_runs_before);
                        error_count++;
                    end
                    if (rsp.affected_count !== e.affected_count)
                    begin
                        $error("affected_count: expected %0d, got %0d", e.affected_count,
                               rsp.affected_count);
                        error_count++;
                    end
                    if (rsp.callbacks_total !== e.callbacks_total)
                    begin
                        $error("callbacks_total: expected %0d, got %0d", e.callbacks_total,
                               rsp.callbacks_total);
                        error_count++;
                    end
                    if (rsp.wakeups_total !== e.wakeups_total)
                    begin
                        $error("wakeups_total: expected %0d, got %0d", e.wakeups_total,
                               rsp.wakeups_total);
                        error_count++;
                    end
                    if (rsp.active_total !== e.active_total)
                    begin
                        $error("active_total: expected %0d, got %0d", e.active_total,
                               rsp.active_total);
                        error_count++;
                    end
                    if (rsp.more_due !== e.more_due)
                    begin
                        $error("more_due: expected %0d, got %0d", e.more_due, rsp.more_due);
                        error_count++;
                    end
                    if (rsp.last !== e.last)
                    begin
                        $error("last: expected %0d, got %0d", e.last, rsp.last);
                        error_count++;
                    end
                end
            end
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial
    begin
        error_count = 0;
        accepted_reqs = 0;
        checked_rsps = 0;
        fires_seen = 0;
        idle_cycles = 0;
        fired_count = '0;
        tick_count = '0;
        for (int i = 0; i < gtts_pkg::TASK_SLOTS; i++)
        begin
            live[i] = 1'b0;
            tbl[i] = '0;
        end
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The idle watchdog limit stays well above the length of a full 16-fire tick.
        while (!(stim_done && expected_rsps.size() == 0) && idle_cycles < WATCHDOG_CYCLES)
            @(posedge clk);
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("watchdog expired with %0d results outstanding", expected_rsps.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            repeat (100) @(posedge clk);
            $display("Covered %0d requests and %0d results, %0d of them task firings.",
                     accepted_reqs, checked_rsps, fires_seen);
            if (error_count == 0 && expected_rsps.size() == 0)
                $display("RESULT: OK");
            else
                $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

/* filelist.f */
rtl/core/gtts_pkg.sv
rtl/core/gtts_req_if.sv
rtl/core/gtts_rsp_if.sv
rtl/core/gtts_ram.sv
rtl/core/gtts_ctrl.sv
rtl/core/gtts_datapath.sv
rtl/core/grouped_timer_task_scheduler_top.sv
tb/tb_pkg.sv
tb/testbench.sv
